// ===== rtl/lge_pkg.sv =====
// Shared types and codes for the life grid engine.
// Payload structs, action codes, result kinds and register indexes.
// No dependencies.
package lge_pkg;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_STEP  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] REG_WRAP_EDGES  = 2'd2;

   localparam logic [6:0] SIZE_RESET = 7'd64;
   localparam logic [6:0] SIZE_MIN   = 7'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] column;
      logic [5:0] row;
      logic       cell_in;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic        cell_out;
      logic [15:0] generation;
   } rsp_payload_type;

endpackage

// ===== rtl/lge_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the row store of the life grid engine. No dependencies.
module lge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/life_grid_engine.sv =====
// Top level of the life grid engine: cell grid, generation sequencer, CSR port.
// Depends on lge_pkg and lge_ram.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_payload_type
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_payload_type
//  csr     | in/out    | APB, pready tied 1   | 32-bit registers at 4*i
//
// The grid is stored one row per RAM word; a single neighbor counter visits one cell
// per cycle. A write fetches its row and writes it back with the new cell; a read
// fetches its row and passes the cell to the output register. A step fetches every row
// of the active area in turn through the single RAM read port.
// After reset a clearing pass writes MAX_HEIGHT rows, one per cycle, before req_ready.
// req_ready is high only when the sequencer is idle; a result waiting in the output
// register does not block it, but a second result holds the sequencer until it moves.
module life_grid_engine
   import lge_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH, ST_CATCH, ST_CELL, ST_WRITE, ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      LD_ITEM, LD_PREV, LD_CUR, LD_NXT
   } load_type;

   // Configuration registers.
   logic [6:0] grid_width_ff;
   logic [6:0] grid_height_ff;
   logic       wrap_edges_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_RESET;
         grid_height_ff <= SIZE_RESET;
         wrap_edges_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_GRID_WIDTH:  grid_width_ff  <= csr_pwdata[6:0];
            REG_GRID_HEIGHT: grid_height_ff <= csr_pwdata[6:0];
            REG_WRAP_EDGES:  wrap_edges_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_GRID_WIDTH:  csr_prdata = {25'b0, grid_width_ff};
         REG_GRID_HEIGHT: csr_prdata = {25'b0, grid_height_ff};
         REG_WRAP_EDGES:  csr_prdata = {31'b0, wrap_edges_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Last column and row index of the active area, after clamping the sizes.
   logic [CW-1:0] w_last;
   logic [RW-1:0] h_last;

   always_comb begin
      if (grid_width_ff < SIZE_MIN) begin
         w_last = CW'(2);
      end else if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(grid_width_ff - 7'd1);
      end
      if (grid_height_ff < SIZE_MIN) begin
         h_last = RW'(2);
      end else if (32'(grid_height_ff) > 32'(MAX_HEIGHT)) begin
         h_last = RW'(MAX_HEIGHT - 1);
      end else begin
         h_last = RW'(grid_height_ff - 7'd1);
      end
   end

   // Sequencer state.
   state_type        state_ff;
   load_type         load_ff;
   logic [RW-1:0]    y_ff;
   logic [CW-1:0]    x_ff;
   logic [RW-1:0]    fetch_row_ff;
   logic [1:0]       req_action_ff;
   logic [CW-1:0]    req_col_ff;
   logic [RW-1:0]    req_row_ff;
   logic             req_cell_ff;
   logic [15:0]      gen_ff;
   rsp_payload_type  res_ff;
   rsp_payload_type  rsp_data_ff;
   logic             rsp_valid_ff;

   // Row window: rows y-1, y, y+1 as they were before this step, the new row y,
   // and the original row 0 for the wrapped bottom neighbor.
   logic [MAX_WIDTH-1:0] prev_ff;
   logic [MAX_WIDTH-1:0] cur_ff;
   logic [MAX_WIDTH-1:0] nxt_ff;
   logic [MAX_WIDTH-1:0] new_row_ff;
   logic [MAX_WIDTH-1:0] row0_ff;

   // RAM ports.
   logic                 ram_wr_en;
   logic [RW-1:0]        ram_wr_addr;
   logic [MAX_WIDTH-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [MAX_WIDTH-1:0] ram_rd_data;

   lge_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (fetch_row_ff),
      .rd_data (ram_rd_data)
   );

   logic item_write;
   assign item_write = (state_ff == ST_CATCH) && (load_ff == LD_ITEM) &&
                       (req_action_ff == ACT_WRITE);

   always_comb begin
      ram_rd_en   = (state_ff == ST_FETCH);
      ram_wr_en   = 1'b0;
      ram_wr_addr = y_ff;
      ram_wr_data = new_row_ff;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = '0;
      end else if (item_write) begin
         ram_wr_en               = 1'b1;
         ram_wr_addr             = req_row_ff;
         ram_wr_data             = ram_rd_data;
         ram_wr_data[req_col_ff] = req_cell_ff;
      end else if (state_ff == ST_WRITE) begin
         ram_wr_en = 1'b1;
      end
   end

   // Shared neighbor counter for the cell at column x_ff.
   logic          left_ok;
   logic          right_ok;
   logic [CW-1:0] lx;
   logic [CW-1:0] rx;
   logic [7:0]    nbrs;
   logic [3:0]    n_count;
   logic [3:0]    n_total;
   logic          new_bit;

   always_comb begin
      left_ok  = (x_ff != '0) || wrap_edges_ff;
      right_ok = (x_ff != w_last) || wrap_edges_ff;
      lx       = (x_ff == '0) ? w_last : x_ff - CW'(1);
      rx       = (x_ff == w_last) ? '0 : x_ff + CW'(1);
      nbrs     = {left_ok & prev_ff[lx], prev_ff[x_ff], right_ok & prev_ff[rx],
                  left_ok & cur_ff[lx],                 right_ok & cur_ff[rx],
                  left_ok & nxt_ff[lx],  nxt_ff[x_ff],  right_ok & nxt_ff[rx]};
      n_count  = 4'($countones(nbrs));
      n_total  = n_count + {3'b0, cur_ff[x_ff]};
      new_bit  = (n_count <= 4'd3) && (n_total >= 4'd3);
   end

   logic req_inside;
   assign req_inside = (32'(req_data.column) <= 32'(w_last)) &&
                       (32'(req_data.row) <= 32'(h_last));

   logic [15:0] gen_next;
   assign gen_next = (gen_ff == 16'hFFFF) ? gen_ff : gen_ff + 16'd1;

   // The output register takes a new result when it is empty or being emptied.
   logic rsp_load;
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         y_ff         <= '0;
         x_ff         <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         load_ff      <= LD_ITEM;
      end else begin
         if (rsp_load) begin
            rsp_data_ff  <= res_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (y_ff == RW'(MAX_HEIGHT - 1)) begin
                  y_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  y_ff <= y_ff + RW'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_action_ff <= req_data.action;
                  req_col_ff    <= CW'(req_data.column);
                  req_row_ff    <= RW'(req_data.row);
                  req_cell_ff   <= req_data.cell_in;
                  x_ff          <= '0;
                  y_ff          <= '0;
                  case (req_data.action)
                     ACT_WRITE: begin
                        fetch_row_ff <= RW'(req_data.row);
                        load_ff      <= LD_ITEM;
                        if (req_inside) begin
                           state_ff <= ST_FETCH;
                        end
                     end
                     ACT_READ: begin
                        fetch_row_ff <= RW'(req_data.row);
                        load_ff      <= LD_ITEM;
                        if (req_inside) begin
                           state_ff <= ST_FETCH;
                        end else begin
                           res_ff   <= '{result_kind: KIND_READ, cell_out: 1'b0,
                                         generation: gen_ff};
                           state_ff <= ST_RESP;
                        end
                     end
                     ACT_STEP: begin
                        state_ff <= ST_FETCH;
                        if (wrap_edges_ff) begin
                           fetch_row_ff <= h_last;
                           load_ff      <= LD_PREV;
                        end else begin
                           prev_ff      <= '0;
                           fetch_row_ff <= '0;
                           load_ff      <= LD_CUR;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_FETCH: begin
               state_ff <= ST_CATCH;
            end
            ST_CATCH: begin
               case (load_ff)
                  LD_ITEM: begin
                     if (req_action_ff == ACT_READ) begin
                        res_ff   <= '{result_kind: KIND_READ,
                                      cell_out: ram_rd_data[req_col_ff],
                                      generation: gen_ff};
                        state_ff <= ST_RESP;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
                  LD_PREV: begin
                     prev_ff      <= ram_rd_data;
                     fetch_row_ff <= '0;
                     load_ff      <= LD_CUR;
                     state_ff     <= ST_FETCH;
                  end
                  LD_CUR: begin
                     cur_ff       <= ram_rd_data;
                     new_row_ff   <= ram_rd_data;
                     row0_ff      <= ram_rd_data;
                     fetch_row_ff <= RW'(1);
                     load_ff      <= LD_NXT;
                     state_ff     <= ST_FETCH;
                  end
                  default: begin
                     nxt_ff   <= ram_rd_data;
                     x_ff     <= '0;
                     state_ff <= ST_CELL;
                  end
               endcase
            end
            ST_CELL: begin
               new_row_ff[x_ff] <= new_bit;
               if (x_ff == w_last) begin
                  state_ff <= ST_WRITE;
               end else begin
                  x_ff <= x_ff + CW'(1);
               end
            end
            ST_WRITE: begin
               if (y_ff == h_last) begin
                  gen_ff   <= gen_next;
                  res_ff   <= '{result_kind: KIND_STEP, cell_out: 1'b0,
                                generation: gen_next};
                  state_ff <= ST_RESP;
               end else begin
                  // Slide the window down by one row; cells beyond the active
                  // columns keep their stored value through new_row_ff.
                  prev_ff    <= cur_ff;
                  cur_ff     <= nxt_ff;
                  new_row_ff <= nxt_ff;
                  y_ff       <= y_ff + RW'(1);
                  x_ff       <= '0;
                  if (y_ff + RW'(1) == h_last) begin
                     nxt_ff   <= wrap_edges_ff ? row0_ff : '0;
                     state_ff <= ST_CELL;
                  end else begin
                     fetch_row_ff <= y_ff + RW'(2);
                     load_ff      <= LD_NXT;
                     state_ff     <= ST_FETCH;
                  end
               end
            end
            ST_RESP: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The generation count never moves backward.
   a_gen_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> gen_ff >= $past(gen_ff))
      else $error("generation count decreased");

   // The row store is written only by the clearing pass, an item write or a row write.
   a_ram_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || item_write || state_ff == ST_WRITE))
      else $error("unexpected row store write");

   // The cell counter stays inside the active columns.
   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL) |-> (x_ff <= w_last))
      else $error("cell column beyond active area");

   // A step row write always targets an active row.
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (y_ff <= h_last))
      else $error("row write beyond active area");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the life grid engine: grid writes, reads and generation steps.
// Predicts every result from its own copy of the grid; depends on lge_pkg and life_grid_engine.
`timescale 1ns / 100ps

module tb_top;
   import lge_pkg::*;

   localparam int GRID_MAX = 64;
   localparam int RANDOM_ITEMS = 100;
   localparam int PHASES = 5;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [1:0] REG_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Predicted state of the block, indexed [row][column].
   bit life_cells [GRID_MAX][GRID_MAX];
   logic [15:0] gen_count;
   logic [6:0] cfg_width_raw;
   logic [6:0] cfg_height_raw;
   logic cfg_wrap;

   rsp_payload_type due_replies [$];
   int error_count;
   bit no_idle;
   int unsigned cycle_count;

   life_grid_engine #(
      .MAX_WIDTH (GRID_MAX),
      .MAX_HEIGHT(GRID_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_span(logic [6:0] raw);
      if (raw < SIZE_MIN) return int'(SIZE_MIN);
      if (raw > GRID_MAX) return GRID_MAX;
      return int'(raw);
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= 10) $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic req_payload_type cell_op(logic [1:0] action, int column, int row, bit alive);
      req_payload_type item;
      item.action = action;
      item.column = 6'(column);
      item.row = 6'(row);
      item.cell_in = alive;
      return item;
   endfunction

   function automatic void advance_generation();
      bit fresh [GRID_MAX][GRID_MAX];
      int w, h, n, rr, cc;
      w = active_span(cfg_width_raw);
      h = active_span(cfg_height_raw);
      fresh = life_cells;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if (dr != 0 || dc != 0) begin
                     if (cfg_wrap) begin
                        if (rr < 0) rr += h;
                        if (rr >= h) rr -= h;
                        if (cc < 0) cc += w;
                        if (cc >= w) cc -= w;
                        n += life_cells[rr][cc];
                     end else if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                        n += life_cells[rr][cc];
                     end
                  end
               end
            end
            fresh[r][c] = (n <= 3) && (n + life_cells[r][c] >= 3);
         end
      end
      life_cells = fresh;
      if (gen_count != 16'hFFFF) gen_count++;
   endfunction

   function automatic void model_life_op(req_payload_type item);
      rsp_payload_type reply;
      bit in_area;
      in_area = (item.column < active_span(cfg_width_raw)) &&
                (item.row < active_span(cfg_height_raw));
      case (item.action)
         ACT_WRITE: begin
            if (in_area) life_cells[item.row][item.column] = item.cell_in;
         end
         ACT_STEP: begin
            advance_generation();
            reply.result_kind = KIND_STEP;
            reply.cell_out = 1'b0;
            reply.generation = gen_count;
            due_replies.push_back(reply);
         end
         ACT_READ: begin
            reply.result_kind = KIND_READ;
            reply.cell_out = in_area ? life_cells[item.row][item.column] : 1'b0;
            reply.generation = gen_count;
            due_replies.push_back(reply);
         end
         default: ;
      endcase
   endfunction

   // Called right after a rising edge; leaves valid high so back-to-back transfers need no
   // lowering in between.
   task automatic issue_cell_op(input req_payload_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      model_life_op(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_GRID_WIDTH:  cfg_width_raw = value[6:0];
         REG_GRID_HEIGHT: cfg_height_raw = value[6:0];
         REG_WRAP_EDGES:  cfg_wrap = value[0];
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [1:0] index);
      logic [31:0] want;
      case (index)
         REG_GRID_WIDTH:  want = {25'd0, cfg_width_raw};
         REG_GRID_HEIGHT: want = {25'd0, cfg_height_raw};
         default:         want = {31'd0, cfg_wrap};
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) note_mismatch("register read", want, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_checker
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_replies.size() == 0) begin
            note_mismatch("unexpected result", 32'd0, {14'd0, rsp_data});
         end else begin
            want = due_replies.pop_front();
            if (rsp_data.result_kind !== want.result_kind)
               note_mismatch("result_kind", {31'd0, want.result_kind},
                             {31'd0, rsp_data.result_kind});
            if (rsp_data.cell_out !== want.cell_out)
               note_mismatch("cell_out", {31'd0, want.cell_out}, {31'd0, rsp_data.cell_out});
            if (rsp_data.generation !== want.generation)
               note_mismatch("generation", {16'd0, want.generation},
                             {16'd0, rsp_data.generation});
         end
      end
   end

   initial begin : rsp_ready_driver
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Full 64 by 64 area straight out of reset, including the far corner.
   task automatic test_reset_defaults();
      issue_cell_op(cell_op(ACT_READ, 0, 0, 0));
      issue_cell_op(cell_op(ACT_READ, 63, 63, 1));
      issue_cell_op(cell_op(ACT_WRITE, 63, 63, 1));
      issue_cell_op(cell_op(ACT_READ, 63, 63, 0));
      issue_cell_op(cell_op(ACT_WRITE, 0, 0, 1));
      issue_cell_op(cell_op(ACT_STEP, 0, 0, 0));
      issue_cell_op(cell_op(ACT_READ, 63, 63, 0));
   endtask

   // Masking of wide write data, a spare register index, and read-back of each register.
   task automatic test_register_access();
      wait_idle();
      csr_write(REG_GRID_WIDTH, 32'd127);
      csr_check(REG_GRID_WIDTH);
      csr_write(REG_GRID_HEIGHT, 32'd0);
      csr_check(REG_GRID_HEIGHT);
      csr_write(REG_WRAP_EDGES, 32'hFFFF_FFFF);
      csr_check(REG_WRAP_EDGES);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      csr_write(REG_GRID_WIDTH, 32'hFFFF_FF83);
      csr_check(REG_GRID_WIDTH);
      csr_check(REG_GRID_HEIGHT);
      csr_check(REG_WRAP_EDGES);
   endtask

   // Sizes below the minimum and above the maximum, with addresses just past the area edge.
   task automatic test_size_clamp();
      wait_idle();
      csr_write(REG_GRID_WIDTH, 32'd1);
      csr_write(REG_GRID_HEIGHT, 32'd200);
      csr_write(REG_WRAP_EDGES, 32'd0);
      issue_cell_op(cell_op(ACT_WRITE, 3, 0, 1));
      issue_cell_op(cell_op(ACT_READ, 3, 0, 1));
      issue_cell_op(cell_op(ACT_WRITE, 2, 63, 1));
      issue_cell_op(cell_op(ACT_READ, 2, 63, 0));
      issue_cell_op(cell_op(ACT_UNUSED, 2, 63, 1));
      issue_cell_op(cell_op(ACT_STEP, 63, 63, 1));
      issue_cell_op(cell_op(ACT_READ, 2, 63, 0));
   endtask

   // A cell left outside a shrunken area must survive a step and reappear when it grows.
   task automatic test_hidden_cells();
      wait_idle();
      csr_write(REG_GRID_WIDTH, 32'd8);
      csr_write(REG_GRID_HEIGHT, 32'd8);
      issue_cell_op(cell_op(ACT_WRITE, 7, 7, 1));
      wait_idle();
      csr_write(REG_GRID_WIDTH, 32'd4);
      issue_cell_op(cell_op(ACT_READ, 7, 7, 0));
      issue_cell_op(cell_op(ACT_STEP, 0, 0, 0));
      wait_idle();
      csr_write(REG_GRID_WIDTH, 32'd8);
      issue_cell_op(cell_op(ACT_READ, 7, 7, 0));
   endtask

   // A blinker that straddles the left and right edges of a periodic 5 by 5 area.
   task automatic test_wrap_blinker();
      wait_idle();
      csr_write(REG_GRID_WIDTH, 32'd5);
      csr_write(REG_GRID_HEIGHT, 32'd5);
      csr_write(REG_WRAP_EDGES, 32'd1);
      issue_cell_op(cell_op(ACT_WRITE, 4, 2, 1));
      issue_cell_op(cell_op(ACT_WRITE, 0, 2, 1));
      issue_cell_op(cell_op(ACT_WRITE, 1, 2, 1));
      issue_cell_op(cell_op(ACT_STEP, 0, 0, 0));
      issue_cell_op(cell_op(ACT_READ, 0, 1, 0));
      issue_cell_op(cell_op(ACT_READ, 0, 2, 0));
      issue_cell_op(cell_op(ACT_READ, 0, 3, 0));
      issue_cell_op(cell_op(ACT_READ, 4, 2, 0));
   endtask

   function automatic logic [31:0] pick_raw_size(bit big);
      int r;
      r = $urandom_range(0, 99);
      if (big) return $urandom_range(40, 64);
      if (r < 10) return $urandom_range(0, 2);
      if (r < 20) return $urandom_range(65, 127);
      return $urandom_range(3, 12);
   endfunction

   function automatic int pick_coord(int span);
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, span - 1);
      return $urandom_range(0, 63);
   endfunction

   // Each phase seeds the area densely, then mixes steps, reads, stray writes and noise.
   task automatic run_random_phase(input int target);
      req_payload_type item;
      int w, h, r, counted;
      bit seeding;
      w = active_span(cfg_width_raw);
      h = active_span(cfg_height_raw);
      counted = 0;
      while (counted < target) begin
         seeding = counted < target / 3;
         if ($urandom_range(0, 99) < 4) wait_idle();
         item.column = 6'(pick_coord(w));
         item.row = 6'(pick_coord(h));
         item.cell_in = $urandom_range(0, 99) < 60;
         r = $urandom_range(0, 99);
         if (r < (seeding ? 75 : 35)) item.action = ACT_WRITE;
         else if (r < (seeding ? 80 : 55)) item.action = ACT_STEP;
         else if (r < 95) item.action = ACT_READ;
         else item.action = ACT_UNUSED;
         issue_cell_op(item);
         if (!(item.action == ACT_UNUSED ||
               (item.action == ACT_WRITE && (item.column >= w || item.row >= h))))
            counted++;
      end
   endtask

   task automatic test_random_evolution();
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         no_idle = (p == 2);
         csr_write(REG_GRID_WIDTH, pick_raw_size(p == 3));
         csr_write(REG_GRID_HEIGHT, pick_raw_size(p == 3));
         csr_write(REG_WRAP_EDGES, $urandom_range(0, 1));
         run_random_phase(RANDOM_ITEMS / PHASES);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      no_idle = 1'b0;
      gen_count = '0;
      cfg_width_raw = SIZE_RESET;
      cfg_height_raw = SIZE_RESET;
      cfg_wrap = 1'b0;
      foreach (life_cells[r, c]) life_cells[r][c] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_access();
      test_size_clamp();
      test_hidden_cells();
      test_wrap_blinker();
      test_random_evolution();
      wait_idle();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
